// ===== design/mfd_pkg.sv =====
// Shared types and constants for the median fire detector.
`timescale 1ns / 1ps
package mfd_pkg;

    localparam int TEMP_W  = 16;
    localparam int LEVEL_W = 3;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_COUNT_NEEDED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD   = 2'd2;

    localparam logic signed [TEMP_W-1:0] RST_HOT_THRESHOLD = 16'sd58;
    localparam logic [CNT_W-1:0]         RST_HOT_COUNT_NEEDED = 5'd27;
    localparam logic [TEMP_W-1:0]        RST_RISE_THRESHOLD = 16'd8;
    localparam logic [CNT_W-1:0]         CNT_SAT = 5'd31;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef struct packed {
        logic load;
        logic shift;
    } t_hist_ctl;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_SORT  = 8'b0000_1000,
        S_MED   = 8'b0001_0000,
        S_SHIFT = 8'b0010_0000,
        S_COUNT = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

// ===== design/mfd_sort_cell.sv =====
// Insertion sort cell: keeps the smallest value seen, passes the larger one on.
`timescale 1ns / 1ps
module mfd_sort_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_in_valid,
    input  mfd_pkg::t_temp i_in_data,
    output logic           o_pass_valid,
    output mfd_pkg::t_temp o_pass_data,
    output mfd_pkg::t_temp o_value
);
    import mfd_pkg::*;

    logic  r_full;
    logic  r_pv;
    t_temp r_val;
    t_temp r_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_full <= 1'b0;
            r_pv   <= 1'b0;
        end else if (i_in_valid) begin
            if (!r_full) begin
                r_full <= 1'b1;
                r_val  <= i_in_data;
                r_pv   <= 1'b0;
            end else if (i_in_data < r_val) begin
                r_val <= i_in_data;
                r_pd  <= r_val;
                r_pv  <= 1'b1;
            end else begin
                r_pd <= i_in_data;
                r_pv <= 1'b1;
            end
        end else begin
            r_pv <= 1'b0;
        end
    end

    assign o_pass_valid = r_pv;
    assign o_pass_data  = r_pd;
    assign o_value      = r_val;

endmodule

// ===== design/mfd_hist_cell.sv =====
// History cell: one smoothed value, loaded in parallel or shifted from its neighbor.
`timescale 1ns / 1ps
module mfd_hist_cell (
    input  logic               i_clk,
    input  mfd_pkg::t_hist_ctl i_ctl,
    input  mfd_pkg::t_temp     i_load_data,
    input  mfd_pkg::t_temp     i_prev,
    output mfd_pkg::t_temp     o_value
);
    import mfd_pkg::*;

    t_temp r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_load_data;
        end else if (i_ctl.shift) begin
            r_val <= i_prev;
        end
    end

    assign o_value = r_val;

endmodule

// ===== design/median_fire_detector_core.sv =====
// Top level of the median fire detector core.
`timescale 1ns / 1ps
// The result of an item (level, sample) is built in steps after it is taken: a row read, the
// window streamed through a chain of MEDIAN_TAPS insertion sort cells, the median pushed
// into a chain of HISTORY_DEPTH history cells, and one full rotation of that chain to count
// hot entries. One item is in flight at a time and the next can be taken in the cycle after
// the result is loaded, so the core cannot take a new item before it is through with the
// last one; a stalled result holds the core in its last step until the output register
// frees up. After reset a clearing pass over all LEVEL_COUNT levels zeroes the window and
// history memories before the first item is accepted; configuration writes are always taken.
module median_fire_detector_core #(
    parameter int LEVEL_COUNT   = 8,
    parameter int MEDIAN_TAPS   = 5,
    parameter int HISTORY_DEPTH = 30
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mfd_pkg::LEVEL_W-1:0]      i_level_index,
    input  mfd_pkg::t_temp                   i_sample_temp,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mfd_pkg::t_temp                   o_smoothed_temp,
    output logic [mfd_pkg::CNT_W-1:0]        o_hot_count,
    output logic                             o_alarm,
    input  logic                             i_cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mfd_pkg::*;

    localparam int LW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int CMAX  = (2 * MEDIAN_TAPS > HISTORY_DEPTH) ? 2 * MEDIAN_TAPS : HISTORY_DEPTH;
    localparam int CW    = $clog2(CMAX + 1);
    localparam int HCW   = $clog2(HISTORY_DEPTH + 1);
    localparam int MID_LO = (MEDIAN_TAPS - 1) / 2;
    localparam int MID_HI = MEDIAN_TAPS / 2;

    t_state r_state;
    logic [LW-1:0] r_clr_addr;
    logic [LW-1:0] r_lvl;
    logic          r_skip;
    t_temp         r_sample;
    logic [CW-1:0] r_cnt;
    logic [MEDIAN_TAPS-1:0][TEMP_W-1:0] r_feed;
    t_temp         r_med;
    logic [HCW-1:0] r_count;
    t_temp         r_thr;
    logic [CNT_W-1:0] r_need;
    logic [TEMP_W-1:0] r_rise;
    logic          r_alarm;
    logic          r_out_valid;
    t_temp         r_out_med;
    logic [CNT_W-1:0] r_out_cnt;

    logic [MEDIAN_TAPS-1:0][TEMP_W-1:0]   r_win_mem [LEVEL_COUNT];
    logic [HISTORY_DEPTH-1:0][TEMP_W-1:0] r_hist_mem [LEVEL_COUNT];
    logic [MEDIAN_TAPS-1:0][TEMP_W-1:0]   r_win_rd;
    logic [HISTORY_DEPTH-1:0][TEMP_W-1:0] r_hist_rd;

    logic [MEDIAN_TAPS-1:0][TEMP_W-1:0]   w_new_win;
    logic [HISTORY_DEPTH-1:0][TEMP_W-1:0] w_hist;
    t_temp w_sorted [MEDIAN_TAPS];
    logic  w_pv [MEDIAN_TAPS+1];
    t_temp w_pd [MEDIAN_TAPS+1];
    t_hist_ctl w_hctl;
    t_temp w_hist_in0;
    logic  w_accept;
    logic  w_lvl_ok;
    logic  w_out_free;
    logic  w_win_we;
    logic  w_hist_we;
    logic [LW-1:0] w_wr_addr;
    logic signed [TEMP_W:0] w_sum;
    t_temp w_med;
    t_temp w_oldest;
    logic signed [TEMP_W:0] w_diff;
    logic  w_trip;
    logic  n_alarm;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_lvl_ok   = (32'(i_level_index) < LEVEL_COUNT);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        for (int i = 0; i < MEDIAN_TAPS; i++) begin
            if (i == 0) begin
                w_new_win[i] = r_sample;
            end else begin
                w_new_win[i] = r_win_rd[i-1];
            end
        end
    end

    assign w_win_we  = (r_state == S_CLEAR) || (r_state == S_READ && !r_skip);
    assign w_hist_we = (r_state == S_CLEAR) || (r_state == S_DONE && w_out_free);
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_lvl;

    always_ff @(posedge i_clk) begin
        if (w_win_we) begin
            r_win_mem[w_wr_addr] <= (r_state == S_CLEAR) ? '0 : w_new_win;
        end
        if (w_hist_we) begin
            r_hist_mem[w_wr_addr] <= (r_state == S_CLEAR) ? '0 : w_hist;
        end
        r_win_rd  <= r_win_mem[LW'(i_level_index)];
        r_hist_rd <= r_hist_mem[LW'(i_level_index)];
    end

    assign w_pv[0] = (r_state == S_SORT) && (32'(r_cnt) < MEDIAN_TAPS);
    assign w_pd[0] = r_feed[0];

    for (genvar g = 0; g < MEDIAN_TAPS; g++) begin : g_sort
        mfd_sort_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_clear      (r_state == S_READ),
            .i_in_valid   (w_pv[g]),
            .i_in_data    (w_pd[g]),
            .o_pass_valid (w_pv[g+1]),
            .o_pass_data  (w_pd[g+1]),
            .o_value      (w_sorted[g])
        );
    end

    assign w_sum = TEMP_W'(0) + {w_sorted[MID_LO][TEMP_W-1], w_sorted[MID_LO]}
                 + {w_sorted[MID_HI][TEMP_W-1], w_sorted[MID_HI]};

    always_comb begin
        if (MEDIAN_TAPS % 2 == 0) begin
            w_med = TEMP_W'((w_sum + {{TEMP_W{1'b0}}, w_sum[TEMP_W]}) >>> 1);
        end else begin
            w_med = w_sorted[MID_HI];
        end
    end

    assign w_hctl.load  = (r_state == S_READ) && !r_skip;
    assign w_hctl.shift = (r_state == S_SHIFT) || (r_state == S_COUNT);
    assign w_hist_in0   = (r_state == S_SHIFT) ? r_med : t_temp'(w_hist[HISTORY_DEPTH-1]);

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_hist
        mfd_hist_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_hctl),
            .i_load_data (t_temp'(r_hist_rd[g])),
            .i_prev      ((g == 0) ? w_hist_in0 : t_temp'(w_hist[(g == 0) ? 0 : g-1])),
            .o_value     (w_hist[g])
        );
    end

    assign w_oldest = t_temp'(w_hist[HISTORY_DEPTH-1]);
    assign w_diff   = {r_med[TEMP_W-1], r_med} - {w_oldest[TEMP_W-1], w_oldest};
    assign w_trip   = (w_oldest != '0) &&
                      ((32'(r_count) >= 32'(r_need)) ||
                       (!w_diff[TEMP_W] && (w_diff[TEMP_W-1:0] >= r_rise)));
    assign n_alarm  = r_alarm || w_trip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= RST_HOT_THRESHOLD;
            r_need <= RST_HOT_COUNT_NEEDED;
            r_rise <= RST_RISE_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOT_THRESHOLD:    r_thr  <= t_temp'(i_cfg_data);
                CFG_HOT_COUNT_NEEDED: r_need <= i_cfg_data[CNT_W-1:0];
                CFG_RISE_THRESHOLD:   r_rise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (32'(r_clr_addr) == LEVEL_COUNT - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_lvl    <= LW'(i_level_index);
                        r_skip   <= !w_lvl_ok;
                        r_sample <= i_sample_temp;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_feed  <= w_new_win;
                    r_cnt   <= '0;
                    r_state <= r_skip ? S_IDLE : S_SORT;
                end
                S_SORT: begin
                    r_feed <= r_feed >> TEMP_W;
                    r_cnt  <= r_cnt + 1'b1;
                    if (32'(r_cnt) == 2 * MEDIAN_TAPS - 1) begin
                        r_state <= S_MED;
                    end
                end
                S_MED: begin
                    r_med   <= w_med;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_count <= '0;
                    r_cnt   <= '0;
                    r_state <= S_COUNT;
                end
                S_COUNT: begin
                    if (w_oldest >= r_thr) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (32'(r_cnt) == HISTORY_DEPTH - 1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_alarm     <= n_alarm;
                        r_out_med   <= r_med;
                        r_out_cnt   <= (32'(r_count) > 32'(CNT_SAT)) ? CNT_SAT
                                                                     : CNT_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_smoothed_temp = r_out_med;
    assign o_hot_count     = r_out_cnt;
    assign o_alarm         = r_alarm;

endmodule

// ===== design/mfd_checker.sv =====
// Port-level checks for the median fire detector core.
`timescale 1ns / 1ps
module mfd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input mfd_pkg::t_temp                 o_smoothed_temp,
    input logic [mfd_pkg::CNT_W-1:0]      o_hot_count,
    input logic                           o_alarm
);
    import mfd_pkg::*;

    logic r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_out_valid && o_alarm) begin
            r_seen <= 1'b1;
        end
    end

    a_alarm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen |-> o_alarm)
        else $error("alarm dropped after being raised");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_smoothed_temp)
            && $stable(o_hot_count) && $stable(o_alarm))
        else $error("stalled result changed");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(!i_out_stall))
        else $error("result dropped without being taken");

endmodule

bind median_fire_detector_core mfd_checker u_mfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_smoothed_temp (o_smoothed_temp),
    .o_hot_count     (o_hot_count),
    .o_alarm         (o_alarm)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the median fire detector core.
`timescale 1ns / 1ps
class fire_scoreboard;
    localparam int LEVELS = 8;
    localparam int TAPS = 5;
    localparam int HIST = 30;

    logic signed [15:0] hot_thr;
    logic [4:0]         need_cnt;
    logic [15:0]        rise_thr;
    logic signed [15:0] raw_win [LEVELS][TAPS];
    logic signed [15:0] med_hist [LEVELS][HIST];
    bit                 alarm_q;
    logic [21:0]        pending [$];
    int                 errors;

    function new();
        hot_thr = 16'sd58;
        need_cnt = 5'd27;
        rise_thr = 16'd8;
        alarm_q = 0;
        errors = 0;
        for (int l = 0; l < LEVELS; l++) begin
            for (int t = 0; t < TAPS; t++) raw_win[l][t] = '0;
            for (int h = 0; h < HIST; h++) med_hist[l][h] = '0;
        end
    endfunction

    function void set_reg(int idx, logic [15:0] val);
        if (idx == 0) hot_thr = val;
        else if (idx == 1) need_cnt = val[4:0];
        else if (idx == 2) rise_thr = val;
    endfunction

    function void note_sample(logic [2:0] lvl, logic signed [15:0] smp);
        logic signed [15:0] srt [TAPS];
        logic signed [15:0] tmp, med, oldest;
        int cnt, diff;
        if (lvl >= LEVELS) return;
        for (int t = TAPS - 1; t > 0; t--) raw_win[lvl][t] = raw_win[lvl][t-1];
        raw_win[lvl][0] = smp;
        for (int t = 0; t < TAPS; t++) srt[t] = raw_win[lvl][t];
        for (int a = 0; a < TAPS; a++)
            for (int b = 0; b < TAPS - 1 - a; b++)
                if (srt[b] > srt[b+1]) begin
                    tmp = srt[b]; srt[b] = srt[b+1]; srt[b+1] = tmp;
                end
        if (TAPS % 2 == 0) med = 16'((int'(srt[(TAPS-1)/2]) + int'(srt[TAPS/2])) / 2);
        else med = srt[TAPS/2];
        for (int h = HIST - 1; h > 0; h--) med_hist[lvl][h] = med_hist[lvl][h-1];
        med_hist[lvl][0] = med;
        cnt = 0;
        for (int h = 0; h < HIST; h++) if (med_hist[lvl][h] >= hot_thr) cnt++;
        oldest = med_hist[lvl][HIST-1];
        if (oldest != 0) begin
            diff = int'(med) - int'(oldest);
            if (cnt >= need_cnt) alarm_q = 1;
            if (diff >= 0 && diff >= int'(rise_thr)) alarm_q = 1;
        end
        pending.push_back({med, (cnt > 31) ? 5'd31 : 5'(cnt), alarm_q});
    endfunction

    function void check_result(logic [15:0] med, logic [4:0] cnt, logic alm);
        logic [21:0] exp_r;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h %0d %b", med, cnt, alm);
            return;
        end
        exp_r = pending.pop_front();
        if (exp_r !== {med, cnt, alm}) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp med %h cnt %0d alarm %b, got med %h cnt %0d alarm %b",
                         exp_r[21:6], exp_r[5:1], exp_r[0], med, cnt, alm);
        end
    endfunction
endclass

module tb;
    import mfd_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [2:0]         level = '0;
    t_temp              sample = '0;
    logic               out_valid;
    logic               out_stall = 0;
    t_temp              smoothed;
    logic [4:0]         hot_cnt;
    logic               alarm;
    logic               cfg_we = 0;
    logic [1:0]         cfg_idx = '0;
    logic [15:0]        cfg_data = '0;
    bit                 hold_rx = 0;
    int                 cycles = 0;
    fire_scoreboard     sb;

    median_fire_detector_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_level_index(level), .i_sample_temp(sample),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_smoothed_temp(smoothed), .o_hot_count(hot_cnt), .o_alarm(alarm),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb: failure");
            $finish;
        end
        if (out_valid && !out_stall) sb.check_result(smoothed, hot_cnt, alarm);
    end

    initial begin : rx_side
        int g;
        forever begin
            @(posedge clk);
            if (hold_rx) out_stall <= 1;
            else begin
                g = gap_len();
                out_stall <= (g > 0);
                if (g > 1) repeat (g - 1) @(posedge clk);
            end
        end
    end

    // valid stays high after an item is taken; the next send or drain decides what follows
    task automatic send(logic [2:0] lv, logic [15:0] smp);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        level <= lv;
        sample <= smp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(lv, smp);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 0;
    endtask

    task automatic well_formed_burst(int n);
        logic [2:0] lv;
        logic signed [15:0] base;
        lv = 3'($urandom_range(0, 7));
        base = 16'(int'($urandom_range(0, 120)) - 20);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) send(3'($urandom), 16'($urandom));
            else send(lv, 16'(int'(base) + int'($urandom_range(0, 4)) * k / 3
                              + int'($urandom_range(0, 6)) - 3));
        end
    endtask

    initial begin : tx_side
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(3'd0, 16'h7fff);
        send(3'd0, 16'h8000);
        send(3'd7, 16'hffff);
        send(3'd7, 16'h0001);
        for (int k = 0; k < 8; k++) send(3'd1, 16'(100 + k * 5));
        send(3'd2, 16'd0);
        drain();
        write_reg(CFG_HOT_COUNT_NEEDED, 16'd0);
        write_reg(CFG_RISE_THRESHOLD, 16'hffff);
        write_reg(CFG_HOT_THRESHOLD, 16'h8000);
        write_reg(2'd3, 16'h1234);
        for (int k = 0; k < 6; k++) send(3'd3, 16'(32'hfff0 - k * 7));
        drain();
        write_reg(CFG_HOT_THRESHOLD, 16'h7fff);
        write_reg(CFG_HOT_COUNT_NEEDED, 16'd30);
        write_reg(CFG_RISE_THRESHOLD, 16'd0);
        for (int k = 0; k < 6; k++) send(3'd4, 16'(50 - k * 3));
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_HOT_THRESHOLD, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                         : 16'(40 + $urandom_range(0, 40)));
            write_reg(CFG_HOT_COUNT_NEEDED, 16'($urandom_range(0, 31)));
            write_reg(CFG_RISE_THRESHOLD, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, 20)));
            if (ph == 2) begin
                hold_rx = 1;
                fork
                    begin repeat (300) @(posedge clk); hold_rx = 0; end
                    well_formed_burst(8);
                join
            end
            for (int b = 0; b < 5; b++) well_formed_burst($urandom_range(8, 16));
            if (ph == 3) drain();
            for (int k = 0; k < 5; k++) send(3'($urandom), 16'($urandom));
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/mfd_pkg.sv
design/mfd_sort_cell.sv
design/mfd_hist_cell.sv
design/median_fire_detector_core.sv
design/mfd_checker.sv
tb/tb.sv
